// ----- rtl/asgpd_pkg.sv -----
// shared constants and item types for the smoothing, gamma and duty hysteresis block
package asgpd_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 10;
    localparam int BAND_W   = 8;

    // averaging window, 2 to 64 samples
    localparam int WINDOW    = 8;
    localparam int POS_W     = $clog2(WINDOW);
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    // floor(log2(WINDOW))
    localparam int WIN_SHIFT = $clog2(WINDOW + 1) - 1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [DUTY_W-1:0]   DUTY_MAX   = DUTY_W'(1000);
    localparam logic [BAND_W-1:0]   BAND_RESET = BAND_W'(2);

    // gamma divide by reciprocal: q = (sq * ceil(2^K / d)) >> K, exact for sq < 2^SQ_W
    localparam int              SQ_W        = 2 * SAMPLE_W;
    localparam longint unsigned GAMMA_DIV   = 64'd16765;
    localparam int              RECIP_SHIFT = SQ_W + 15;
    localparam longint unsigned RECIP_VAL   =
        ((64'd1 << RECIP_SHIFT) + GAMMA_DIV - 64'd1) / GAMMA_DIV;
    localparam int              RECIP_W     = $clog2(RECIP_VAL + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
    localparam int              PROD_W      = SQ_W + RECIP_W;
    localparam int              QUOT_W      = PROD_W - RECIP_SHIFT;

    // item after the averaging stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
    } avg_item_t;

    // item after squaring
    typedef struct packed {
        logic [SQ_W-1:0]     square;
        logic [SAMPLE_W-1:0] filtered;
    } sq_item_t;

    // item after the constant divide
    typedef struct packed {
        logic [QUOT_W-1:0]   quot;
        logic [SAMPLE_W-1:0] filtered;
    } quot_item_t;

endpackage

// ----- rtl/asgpd_avg.sv -----
// sample ring, running sum and moving-average output register
module asgpd_avg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [asgpd_pkg::SAMPLE_W-1:0]      in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output asgpd_pkg::avg_item_t                out_item
);

    logic [asgpd_pkg::SAMPLE_W-1:0] hist_reg [asgpd_pkg::WINDOW];
    logic [asgpd_pkg::SUM_W-1:0]    sum_reg;
    logic [asgpd_pkg::SUM_W-1:0]    sum_next;
    logic [asgpd_pkg::SUM_W-1:0]    shifted;
    logic [asgpd_pkg::POS_W-1:0]    pos_reg;
    logic [asgpd_pkg::POS_W-1:0]    pos_next;
    logic                           valid_reg;
    asgpd_pkg::avg_item_t           item_reg;
    asgpd_pkg::avg_item_t           item_next;
    logic                           accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // swap oldest sample for the new one in the sum
    always_comb begin
        sum_next = sum_reg - asgpd_pkg::SUM_W'(hist_reg[pos_reg])
                 + asgpd_pkg::SUM_W'(in_sample);
        if (pos_reg == asgpd_pkg::POS_W'(asgpd_pkg::WINDOW - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
        shifted = sum_next >> asgpd_pkg::WIN_SHIFT;
        if (shifted > asgpd_pkg::SUM_W'(asgpd_pkg::SAMPLE_MAX)) begin
            item_next.filtered = asgpd_pkg::SAMPLE_MAX;
        end else begin
            item_next.filtered = shifted[asgpd_pkg::SAMPLE_W-1:0];
        end
    end

    // ring state, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < asgpd_pkg::WINDOW; i++) begin
                hist_reg[i] <= '0;
            end
            sum_reg <= '0;
            pos_reg <= '0;
        end else if (accept) begin
            hist_reg[pos_reg] <= in_sample;
            sum_reg           <= sum_next;
            pos_reg           <= pos_next;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/asgpd_gamma.sv -----
// two-stage gamma curve: square, then divide by the gamma constant
module asgpd_gamma (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  asgpd_pkg::avg_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output asgpd_pkg::quot_item_t   out_item
);

    logic                           sq_valid_reg;
    asgpd_pkg::sq_item_t            sq_reg;
    logic                           sq_ready;
    logic                           q_valid_reg;
    asgpd_pkg::quot_item_t          q_reg;
    logic [asgpd_pkg::PROD_W-1:0]   prod;

    assign sq_ready  = !q_valid_reg || out_ready;
    assign in_ready  = !sq_valid_reg || sq_ready;
    assign out_valid = q_valid_reg;
    assign out_item  = q_reg;

    // reciprocal multiply, top bits are the quotient
    assign prod = asgpd_pkg::PROD_W'(sq_reg.square) * asgpd_pkg::PROD_W'(asgpd_pkg::RECIP);

    // square stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (in_ready) begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sq_reg.square   <= asgpd_pkg::SQ_W'(in_item.filtered) *
                               asgpd_pkg::SQ_W'(in_item.filtered);
            sq_reg.filtered <= in_item.filtered;
        end
    end

    // divide stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (sq_ready) begin
            q_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_valid_reg && sq_ready) begin
            q_reg.quot     <= prod[asgpd_pkg::PROD_W-1:asgpd_pkg::RECIP_SHIFT];
            q_reg.filtered <= sq_reg.filtered;
        end
    end

endmodule

// ----- rtl/asgpd_hyst.sv -----
// duty clamp, hysteresis against the held duty, and result register
module asgpd_hyst (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [asgpd_pkg::BAND_W-1:0]        band,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  asgpd_pkg::quot_item_t               in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [asgpd_pkg::DUTY_W-1:0]        out_duty,
    output logic                                out_changed,
    output logic [asgpd_pkg::SAMPLE_W-1:0]      out_filtered
);

    logic [asgpd_pkg::DUTY_W-1:0]   held_reg;
    logic                           held_valid_reg;
    logic                           valid_reg;
    logic                           changed_reg;
    logic [asgpd_pkg::SAMPLE_W-1:0] filt_reg;
    logic [asgpd_pkg::DUTY_W-1:0]   duty;
    logic [asgpd_pkg::DUTY_W:0]     duty_x;
    logic [asgpd_pkg::DUTY_W:0]     held_x;
    logic [asgpd_pkg::DUTY_W:0]     band_x;
    logic                           upd;
    logic                           accept;

    assign in_ready     = !valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign out_valid    = valid_reg;
    assign out_duty     = held_reg;
    assign out_changed  = changed_reg;
    assign out_filtered = filt_reg;

    // clamp and update rule
    always_comb begin
        if (in_item.quot > asgpd_pkg::QUOT_W'(asgpd_pkg::DUTY_MAX)) begin
            duty = asgpd_pkg::DUTY_MAX;
        end else begin
            duty = asgpd_pkg::DUTY_W'(in_item.quot);
        end
        duty_x = {1'b0, duty};
        held_x = {1'b0, held_reg};
        band_x = (asgpd_pkg::DUTY_W + 1)'(band);
        upd = !held_valid_reg
            || (duty_x > held_x + band_x)
            || (duty_x + band_x < held_x)
            || (duty == '0)
            || (duty == asgpd_pkg::DUTY_MAX);
    end

    // held duty and result flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept && upd) begin
                held_reg       <= duty;
                held_valid_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            changed_reg <= upd;
            filt_reg    <= in_item.filtered;
        end
    end

endmodule

// ----- rtl/adc_smooth_gamma_pwm_duty_top.sv -----
// Moving-average sample smoothing, squared gamma curve and duty hysteresis.
// An accepted item passes the average, square, divide and hysteresis registers to its result on the m_ side.
// Throughput: one item per cycle; average, square, divide and hysteresis stages
// each hold one item and advance whenever the stage after them can take one.
// Reset (aresetn low, synchronous): sample ring, running sum, ring position and
// held duty cleared, no duty held yet, hysteresis band back to 2.
module adc_smooth_gamma_pwm_duty_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: hysteresis band
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] sample
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [9:0] duty, [21:10] filtered
    output logic [0:0]  m_tuser     // [0] duty_changed
);

    logic [asgpd_pkg::BAND_W-1:0]   band_reg;
    logic                           avg_valid;
    logic                           avg_ready;
    asgpd_pkg::avg_item_t           avg_item;
    logic                           q_valid;
    logic                           q_ready;
    asgpd_pkg::quot_item_t          q_item;
    logic [asgpd_pkg::DUTY_W-1:0]   duty;
    logic                           changed;
    logic [asgpd_pkg::SAMPLE_W-1:0] filtered;

    // band register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg <= asgpd_pkg::BAND_RESET;
        end else if (cfg_wr_en) begin
            band_reg <= cfg_wr_data;
        end
    end

    // moving average
    asgpd_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[asgpd_pkg::SAMPLE_W-1:0]),
        .out_valid (avg_valid),
        .out_ready (avg_ready),
        .out_item  (avg_item)
    );

    // gamma curve
    asgpd_gamma u_gamma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (avg_valid),
        .in_ready  (avg_ready),
        .in_item   (avg_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // hysteresis and result register
    asgpd_hyst u_hyst (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .band         (band_reg),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_item      (q_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_duty     (duty),
        .out_changed  (changed),
        .out_filtered (filtered)
    );

    // result packing
    assign m_tdata = {2'b00, filtered, duty};
    assign m_tuser = changed;

endmodule

// ----- bench/adc_smooth_gamma_pwm_duty_top_tb.sv -----
// testbench for the smoothing, gamma and duty hysteresis block: predicts every result and checks it
`timescale 1ns / 1ps

module adc_smooth_gamma_pwm_duty_top_tb;

    localparam int          GAMMA_DIVISOR = 16765;
    localparam int          DUTY_TOP      = 1000;
    localparam int          STALL_PCT     = 22;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          WATCHDOG_MAX  = 4000;
    localparam logic [7:0]  BAND_AT_RESET = 8'd2;

    // one expected result item
    typedef struct {
        logic [9:0]  duty;
        logic        changed;
        logic [11:0] filtered;
    } duty_result_t;

    // tracks ring, running sum and held duty; holds the expected results
    class duty_tracker;
        logic [11:0]  ring [asgpd_pkg::WINDOW];
        int unsigned  sum;
        int unsigned  pos;
        int unsigned  shift;
        int unsigned  held;
        bit           held_ok;
        int unsigned  band;
        duty_result_t expected_duty [$];
        int           errors;
        int           samples;
        int           updates;
        int           at_full;
        int           at_zero;
        int           band_writes;

        function new();
            int unsigned w;
            foreach (ring[i]) ring[i] = '0;
            sum     = 0;
            pos     = 0;
            held    = 0;
            held_ok = 0;
            band    = BAND_AT_RESET;
            shift   = 0;
            w       = asgpd_pkg::WINDOW;
            while (w > 1) begin
                w = w >> 1;
                shift++;
            end
        endfunction

        function void set_band(logic [7:0] value);
            band = value;
            band_writes++;
        endfunction

        function int pending();
            return expected_duty.size();
        endfunction

        // accepted sample: advance the ring and predict the result
        function void take_sample(logic [11:0] smp);
            int unsigned  filt;
            int unsigned  next_duty;
            bit           upd;
            duty_result_t r;
            sum       = sum - ring[pos] + smp;
            ring[pos] = smp;
            pos       = (pos + 1) % asgpd_pkg::WINDOW;
            filt      = sum >> shift;
            if (filt > 4095) filt = 4095;
            next_duty = (filt * filt) / GAMMA_DIVISOR;
            if (next_duty > DUTY_TOP) next_duty = DUTY_TOP;
            upd = !held_ok || next_duty > held + band || next_duty + band < held
                || next_duty == 0 || next_duty == DUTY_TOP;
            if (upd) begin
                held    = next_duty;
                held_ok = 1;
                updates++;
            end
            if (held == DUTY_TOP) at_full++;
            if (held == 0) at_zero++;
            samples++;
            r.duty     = 10'(held);
            r.changed  = upd;
            r.filtered = 12'(filt);
            expected_duty.push_back(r);
        endfunction

        // accepted result: compare with the oldest prediction
        function void check_duty(logic [9:0] duty, logic changed, logic [11:0] filtered);
            duty_result_t r;
            if (expected_duty.size() == 0) begin
                $error("result with nothing expected: duty %0d filtered %0d", duty, filtered);
                errors++;
                return;
            end
            r = expected_duty.pop_front();
            if (duty !== r.duty) begin
                $error("duty mismatch: expected %0d, got %0d", r.duty, duty);
                errors++;
            end
            if (changed !== r.changed) begin
                $error("duty_changed mismatch: expected %0d, got %0d", r.changed, changed);
                errors++;
            end
            if (filtered !== r.filtered) begin
                $error("filtered mismatch: expected %0d, got %0d", r.filtered, filtered);
                errors++;
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    duty_tracker tracker;
    bit          no_idle = 1'b0;
    int          level   = 2048;
    int          idle_cycles = 0;

    adc_smooth_gamma_pwm_duty_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= STALL_PCT);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_duty(m_tdata[9:0], m_tuser[0], m_tdata[21:10]);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [11:0] smp);
        while (!no_idle && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        do @(posedge aclk); while (!s_tready);
        tracker.take_sample(smp);
    endtask

    // hold off input until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_band(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_band(value);
    endtask

    // mostly slow walks so hysteresis matters, plus jumps, noise, extremes and single-bit patterns
    function automatic logic [11:0] next_sample();
        int pick;
        int step;
        pick = $urandom_range(99);
        if (pick < 5) begin
            level = $urandom_range(4095);
        end else if (pick < 60) begin
            step  = ($urandom_range(3) == 0) ? 96 : 6;
            level = level + int'($urandom_range(2 * step)) - step;
            if (level < 0) level = 0;
            if (level > 4095) level = 4095;
        end else if (pick < 78) begin
            return 12'($urandom_range(4095));
        end else if (pick < 90) begin
            return ($urandom_range(1) == 1) ? 12'hFFF : 12'h000;
        end else if (pick < 95) begin
            return 12'(1) << $urandom_range(11);
        end else begin
            return ~(12'(1) << $urandom_range(11));
        end
        return 12'(level);
    endfunction

    task automatic run_phase(input logic [7:0] band_value, input int count,
                             input bit quiet);
        wait_drained();
        write_band(band_value);
        no_idle = quiet;
        repeat (count) send_sample(next_sample());
        no_idle = 1'b0;
    endtask

    initial begin
        logic [11:0] directed [$];
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // start-up ramp to full scale, ramp back to zero, then bit patterns
        repeat (asgpd_pkg::WINDOW) directed.push_back(12'hFFF);
        repeat (asgpd_pkg::WINDOW) directed.push_back(12'h000);
        directed.push_back(12'h555);
        directed.push_back(12'hAAA);
        directed.push_back(12'h800);
        directed.push_back(12'h001);
        directed.push_back(12'h7FF);
        directed.push_back(12'hFFE);
        foreach (directed[i]) send_sample(directed[i]);

        // band settings: none, widest, reset value with no idling, narrowest, random
        run_phase(8'd0, 120, 1'b0);
        run_phase(8'd255, 120, 1'b0);
        run_phase(BAND_AT_RESET, 150, 1'b1);
        run_phase(8'd1, 120, 1'b0);
        run_phase(8'($urandom_range(3, 40)), 120, 1'b0);
        run_phase(8'($urandom_range(255)), 120, 1'b0);

        wait_drained();
        $display("covered %0d samples under %0d band settings: %0d duty updates",
                 tracker.samples, tracker.band_writes + 1, tracker.updates);
        $display("results at full-scale duty: %0d, at zero duty: %0d",
                 tracker.at_full, tracker.at_zero);
        if (tracker.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
